/* design/pcxrle_pkg.sv */
// ----------------------------------------------------------------------------
// pcxrle_pkg
// shared types and constants for the pcx run-length scan-line decoder
// ----------------------------------------------------------------------------
package pcxrle_pkg;

   localparam int CMD_DEPTH = 4;

   localparam logic [15:0] BPL_RESET  = 16'd80;
   localparam logic [7:0]  PLC_RESET  = 8'd1;
   localparam logic [15:0] LNC_RESET  = 16'd1;
   localparam logic [31:0] DLEN_RESET = 32'd0;

   localparam logic [1:0] RUN_MARK = 2'b11;

   typedef enum logic [1:0] {
      REG_BYTES_PER_LINE = 2'd0,
      REG_PLANE_COUNT    = 2'd1,
      REG_LINE_COUNT     = 2'd2,
      REG_DATA_LENGTH    = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_DATA    = 2'd0,
      ST_OVERRUN = 2'd1,
      ST_AFTER   = 2'd2,
      ST_UNUSED  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMD_LIT     = 2'd0,
      CMD_RUN     = 2'd1,
      CMD_COUNT   = 2'd2,
      CMD_OVERRUN = 2'd3
   } cmd_kind_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_EXEC = 1'b1
   } back_state_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic [5:0]   run_len;
   } cmd_type;

   typedef struct packed {
      logic [15:0] bytes_per_line;
      logic [7:0]  plane_count;
      logic [15:0] line_count;
   } geom_type;

endpackage

/* design/pcxrle_front.sv */
// ----------------------------------------------------------------------------
// pcxrle_front
// accepts encoded bytes, counts them against the data length and classifies
// each one as literal, run count, run data or overrun
// ----------------------------------------------------------------------------
module pcxrle_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic [7:0]         data_in,
   input  logic [31:0]        data_length,
   output pcxrle_pkg::cmd_type cmd
);
   import pcxrle_pkg::*;

   logic        run_pending_ff, run_pending_in;
   logic [5:0]  run_len_ff, run_len_in;
   logic [31:0] consumed_ff, consumed_in;
   logic        overrun;

   always_comb begin
      consumed_in    = consumed_ff;
      run_pending_in = run_pending_ff;
      run_len_in     = run_len_ff;
      if (consumed_ff != 32'hFFFF_FFFF) begin
         consumed_in = consumed_ff + 32'd1;
      end
      overrun     = consumed_in > data_length;
      cmd.data    = data_in;
      cmd.run_len = run_len_ff;
      if (overrun) begin
         cmd.kind = CMD_OVERRUN;
      end else if (run_pending_ff) begin
         cmd.kind       = CMD_RUN;
         run_pending_in = 1'b0;
         run_len_in     = 6'd0;
      end else if (data_in[7:6] == RUN_MARK) begin
         cmd.kind       = CMD_COUNT;
         run_pending_in = 1'b1;
         run_len_in     = data_in[5:0];
      end else begin
         cmd.kind = CMD_LIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_pending_ff <= 1'b0;
         run_len_ff     <= 6'd0;
         consumed_ff    <= 32'd0;
      end else if (take) begin
         run_pending_ff <= run_pending_in;
         run_len_ff     <= run_len_in;
         consumed_ff    <= consumed_in;
      end
   end

endmodule

/* design/pcxrle_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// pcxrle_cmd_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module pcxrle_cmd_fifo #(
   parameter int DEPTH = pcxrle_pkg::CMD_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pcxrle_pkg::cmd_type push_cmd,
   output logic                full,
   input  logic                pop,
   output pcxrle_pkg::cmd_type pop_cmd,
   output logic                empty
);
   import pcxrle_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   cmd_type         slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = count_ff == FULL_CNT;
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("command queue count beyond depth");

endmodule

/* design/pcxrle_back.sv */
// ----------------------------------------------------------------------------
// pcxrle_back
// carries out queued commands: expands runs, tracks column, plane and line,
// and holds the result register
// ----------------------------------------------------------------------------
module pcxrle_back (
   input  logic                 clock,
   input  logic                 reset,
   input  pcxrle_pkg::geom_type geom,
   input  logic                 cmd_empty,
   input  pcxrle_pkg::cmd_type  cmd_head,
   output logic                 cmd_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [7:0]           rsp_pixel_byte,
   output logic [15:0]          rsp_column,
   output logic [7:0]           rsp_plane,
   output logic [15:0]          rsp_line,
   output logic                 rsp_last_of_item,
   output logic                 rsp_image_done,
   output logic [1:0]           rsp_status
);
   import pcxrle_pkg::*;

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff;
   logic [5:0]     remain_ff, remain_in;
   logic [15:0]    col_ff, col_in;
   logic [7:0]     pl_ff, pl_in;
   logic [15:0]    ln_ff, ln_in;
   logic           finished_ff, finished_in;

   logic           valid_ff, valid_in;
   logic [7:0]     px_ff, px_in;
   logic [15:0]    ocol_ff, ocol_in;
   logic [7:0]     opl_ff, opl_in;
   logic [15:0]    oln_ff, oln_in;
   logic           last_ff, last_in;
   logic           done_ff, done_in;
   status_type     st_ff, st_in;

   logic           out_free;
   logic [15:0]    bpl_eff, lnc_eff;
   logic [7:0]     plc_eff;
   logic [16:0]    col_inc, ln_inc;
   logic [8:0]     pl_inc;
   logic           line_end, plane_end, image_end;
   logic           advance;

   assign out_free = !valid_ff || rsp_pop;
   assign bpl_eff  = (geom.bytes_per_line == 16'd0) ? 16'd1 : geom.bytes_per_line;
   assign plc_eff  = (geom.plane_count == 8'd0) ? 8'd1 : geom.plane_count;
   assign lnc_eff  = (geom.line_count == 16'd0) ? 16'd1 : geom.line_count;
   assign col_inc  = {1'b0, col_ff} + 17'd1;
   assign pl_inc   = {1'b0, pl_ff} + 9'd1;
   assign ln_inc   = {1'b0, ln_ff} + 17'd1;
   assign line_end  = col_inc >= {1'b0, bpl_eff};
   assign plane_end = pl_inc >= {1'b0, plc_eff};
   assign image_end = ln_inc >= {1'b0, lnc_eff};

   // position update for one decoded byte
   always_comb begin
      col_in      = col_ff;
      pl_in       = pl_ff;
      ln_in       = ln_ff;
      finished_in = finished_ff;
      if (advance) begin
         if (line_end) begin
            col_in = 16'd0;
            if (plane_end) begin
               pl_in = 8'd0;
               if (image_end) begin
                  ln_in       = 16'd0;
                  finished_in = 1'b1;
               end else begin
                  ln_in = ln_inc[15:0];
               end
            end else begin
               pl_in = pl_inc[7:0];
            end
         end else begin
            col_in = col_inc[15:0];
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      remain_in = remain_ff;
      cmd_pop   = 1'b0;
      advance   = 1'b0;
      valid_in  = valid_ff && !rsp_pop;
      px_in     = px_ff;
      ocol_in   = ocol_ff;
      opl_in    = opl_ff;
      oln_in    = oln_ff;
      last_in   = last_ff;
      done_in   = done_ff;
      st_in     = st_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop   = 1'b1;
               remain_in = cmd_head.run_len;
               state_in  = BK_EXEC;
            end
         end
         BK_EXEC: begin
            if (finished_ff) begin
               if (out_free) begin
                  valid_in = 1'b1;
                  px_in    = 8'd0;
                  ocol_in  = 16'd0;
                  opl_in   = 8'd0;
                  oln_in   = 16'd0;
                  last_in  = 1'b1;
                  done_in  = 1'b0;
                  st_in    = ST_AFTER;
                  state_in = BK_IDLE;
               end
            end else begin
               case (cmd_ff.kind)
                  CMD_COUNT: begin
                     state_in = BK_IDLE;
                  end
                  CMD_OVERRUN: begin
                     if (out_free) begin
                        valid_in = 1'b1;
                        px_in    = 8'd0;
                        ocol_in  = 16'd0;
                        opl_in   = 8'd0;
                        oln_in   = 16'd0;
                        last_in  = 1'b1;
                        done_in  = 1'b0;
                        st_in    = ST_OVERRUN;
                        state_in = BK_IDLE;
                     end
                  end
                  CMD_LIT, CMD_RUN: begin
                     if (cmd_ff.kind == CMD_RUN && remain_ff == 6'd0) begin
                        state_in = BK_IDLE;
                     end else if (out_free) begin
                        advance  = 1'b1;
                        valid_in = 1'b1;
                        px_in    = cmd_ff.data;
                        ocol_in  = col_ff;
                        opl_in   = pl_ff;
                        oln_in   = ln_ff;
                        done_in  = line_end && plane_end && image_end;
                        st_in    = ST_DATA;
                        last_in  = (cmd_ff.kind == CMD_LIT) || (remain_ff == 6'd1) ||
                                   line_end;
                        remain_in = remain_ff - 6'd1;
                        if (last_in) begin
                           state_in = BK_IDLE;
                        end
                     end
                  end
                  default: begin
                     state_in = BK_IDLE;
                  end
               endcase
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_IDLE;
         remain_ff   <= 6'd0;
         col_ff      <= 16'd0;
         pl_ff       <= 8'd0;
         ln_ff       <= 16'd0;
         finished_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         remain_ff   <= remain_in;
         col_ff      <= col_in;
         pl_ff       <= pl_in;
         ln_ff       <= ln_in;
         finished_ff <= finished_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff <= cmd_head;
      end
      px_ff   <= px_in;
      ocol_ff <= ocol_in;
      opl_ff  <= opl_in;
      oln_ff  <= oln_in;
      last_ff <= last_in;
      done_ff <= done_in;
      st_ff   <= st_in;
   end

   assign rsp_empty        = !valid_ff;
   assign rsp_pixel_byte   = px_ff;
   assign rsp_column       = ocol_ff;
   assign rsp_plane        = opl_ff;
   assign rsp_line         = oln_ff;
   assign rsp_last_of_item = last_ff;
   assign rsp_image_done   = done_ff;
   assign rsp_status       = st_ff;

   a_finished_sticky: assert property (@(posedge clock) disable iff (reset)
      finished_ff |=> finished_ff)
      else $error("finished flag dropped");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && st_ff != ST_DATA) |-> (last_ff && !done_ff && px_ff == 8'd0))
      else $error("error transaction not marked last");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && done_ff) |-> (last_ff && finished_ff))
      else $error("image end without last or finished");

endmodule

/* design/pcx_rle_scanline_decoder_core.sv */
// ----------------------------------------------------------------------------
// pcx_rle_scanline_decoder_core
// pcx run-length decoder for the image data after the 128-byte header
// ----------------------------------------------------------------------------
// input: one encoded byte per transaction on req_data_in, taken when req_push
// is high and req_full is low. a front stage counts and classifies each byte
// and queues a command; a back stage expands it into decoded bytes.
// results: the oldest result sits on the rsp_ ports while rsp_empty is low
// and is taken when rsp_pop is high. each byte with its column, plane, line.
// a run count byte gives no result; its data byte gives up to 63 results,
// cut short at the end of the plane line. status 1 flags a byte beyond the
// configured data length, status 2 a byte after the image is complete.
// the back stage pops a command while idle, then carries it out; within a
// run it emits one result per cycle while the result register is free.
// a stalled receiver holds the result register; the command queue then
// fills and req_full rises. csr_ writes load geometry and data length and
// must be made by the user only while the block is idle; the block does
// not enforce it. reset clears all positions and counts and reloads the
// register defaults.
// ----------------------------------------------------------------------------
module pcx_rle_scanline_decoder_core #(
   parameter int CMD_DEPTH = pcxrle_pkg::CMD_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_in,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_pixel_byte,
   output logic [15:0] rsp_column,
   output logic [7:0]  rsp_plane,
   output logic [15:0] rsp_line,
   output logic        rsp_last_of_item,
   output logic        rsp_image_done,
   output logic [1:0]  rsp_status,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import pcxrle_pkg::*;

   logic [15:0] bpl_ff;
   logic [7:0]  plc_ff;
   logic [15:0] lnc_ff;
   logic [31:0] dlen_ff;
   geom_type    geom;
   cmd_type     front_cmd, head_cmd;
   logic        take, q_empty, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpl_ff  <= BPL_RESET;
         plc_ff  <= PLC_RESET;
         lnc_ff  <= LNC_RESET;
         dlen_ff <= DLEN_RESET;
      end else if (csr_write_enable) begin
         case (reg_index_type'(csr_index))
            REG_BYTES_PER_LINE: bpl_ff  <= csr_write_data[15:0];
            REG_PLANE_COUNT:    plc_ff  <= csr_write_data[7:0];
            REG_LINE_COUNT:     lnc_ff  <= csr_write_data[15:0];
            REG_DATA_LENGTH:    dlen_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign geom.bytes_per_line = bpl_ff;
   assign geom.plane_count    = plc_ff;
   assign geom.line_count     = lnc_ff;
   assign take = req_push && !req_full;

   pcxrle_front u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .data_in     (req_data_in),
      .data_length (dlen_ff),
      .cmd         (front_cmd)
   );

   pcxrle_cmd_fifo #(
      .DEPTH (CMD_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (take),
      .push_cmd (front_cmd),
      .full     (req_full),
      .pop      (q_pop),
      .pop_cmd  (head_cmd),
      .empty    (q_empty)
   );

   pcxrle_back u_back (
      .clock            (clock),
      .reset            (reset),
      .geom             (geom),
      .cmd_empty        (q_empty),
      .cmd_head         (head_cmd),
      .cmd_pop          (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_pixel_byte   (rsp_pixel_byte),
      .rsp_column       (rsp_column),
      .rsp_plane        (rsp_plane),
      .rsp_line         (rsp_line),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_image_done   (rsp_image_done),
      .rsp_status       (rsp_status)
   );

endmodule
